// File: rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, segment codes and glyph lookup for the four-digit display driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

    typedef enum logic [1:0] {
        KIND_NUMBER = 2'd0,
        KIND_CHAR   = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_TICK   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] value;
        logic [2:0]         point_position;
        logic [2:0]         digit_position;
        logic [7:0]         char_code;
    } item_t;

    typedef struct packed {
        logic [7:0] segment_byte;
        logic [3:0] digit_enable;
        logic [1:0] digit_index;
    } result_t;

    typedef logic [3:0][7:0] patterns_t;

    localparam logic [7:0] SEG_A = 8'h01;
    localparam logic [7:0] SEG_B = 8'h02;
    localparam logic [7:0] SEG_C = 8'h04;
    localparam logic [7:0] SEG_D = 8'h08;
    localparam logic [7:0] SEG_E = 8'h10;
    localparam logic [7:0] SEG_F = 8'h20;
    localparam logic [7:0] SEG_G = 8'h40;
    localparam logic [7:0] SEG_P = 8'h80;

    localparam logic [7:0] BLANK_BYTE = 8'hFF;
    localparam logic [7:0] MINUS_BYTE = BLANK_BYTE ^ SEG_G;

    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_COMMA      = 8'h2C;
    localparam logic [7:0] CHAR_MINUS      = 8'h2D;
    localparam logic [7:0] CHAR_DOT        = 8'h2E;
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_NINE       = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;

    localparam logic [4:0] LETTER_O = 5'd14;
    localparam logic [4:0] LETTER_T = 5'd19;
    localparam logic [4:0] LETTER_U = 5'd20;

    function automatic logic [7:0] lit(input logic [7:0] mask);
        return BLANK_BYTE ^ mask;
    endfunction

    function automatic logic [7:0] num_pattern(input logic [3:0] d);
        logic [7:0] p;
        case (d)
            4'd0: p = lit(SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F);
            4'd1: p = lit(SEG_B | SEG_C);
            4'd2: p = lit(SEG_A | SEG_B | SEG_D | SEG_E | SEG_G);
            4'd3: p = lit(SEG_A | SEG_B | SEG_C | SEG_D | SEG_G);
            4'd4: p = lit(SEG_B | SEG_C | SEG_F | SEG_G);
            4'd5: p = lit(SEG_A | SEG_C | SEG_D | SEG_F | SEG_G);
            4'd6: p = lit(SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G);
            4'd7: p = lit(SEG_A | SEG_B | SEG_C);
            4'd8: p = lit(SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G);
            4'd9: p = lit(SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G);
            default: p = BLANK_BYTE;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] letter_pattern(input logic [4:0] idx);
        logic [7:0] p;
        case (idx)
            5'd0:  p = lit(SEG_A | SEG_B | SEG_C | SEG_E | SEG_F | SEG_G);
            5'd1:  p = lit(SEG_C | SEG_D | SEG_E | SEG_F | SEG_G);
            5'd2:  p = lit(SEG_D | SEG_E | SEG_G);
            5'd3:  p = lit(SEG_B | SEG_C | SEG_D | SEG_E | SEG_G);
            5'd4:  p = lit(SEG_A | SEG_D | SEG_E | SEG_F | SEG_G);
            5'd5:  p = lit(SEG_A | SEG_E | SEG_F | SEG_G);
            5'd6:  p = lit(SEG_A | SEG_C | SEG_D | SEG_E | SEG_F);
            5'd7:  p = lit(SEG_C | SEG_E | SEG_F | SEG_G);
            5'd8:  p = lit(SEG_C);
            5'd9:  p = lit(SEG_B | SEG_C | SEG_D | SEG_E);
            5'd10: p = lit(SEG_B | SEG_C | SEG_E | SEG_F | SEG_G);
            5'd11: p = lit(SEG_D | SEG_E | SEG_F);
            5'd12: p = lit(SEG_A | SEG_B | SEG_C | SEG_E | SEG_F);
            5'd13: p = lit(SEG_C | SEG_E | SEG_G);
            5'd14: p = lit(SEG_C | SEG_D | SEG_E | SEG_G);
            5'd15: p = lit(SEG_A | SEG_B | SEG_E | SEG_F | SEG_G);
            5'd16: p = lit(SEG_A | SEG_B | SEG_C | SEG_F | SEG_G);
            5'd17: p = lit(SEG_E | SEG_G);
            5'd18: p = lit(SEG_A | SEG_C | SEG_D | SEG_F | SEG_G);
            5'd19: p = lit(SEG_D | SEG_E | SEG_F | SEG_G);
            5'd20: p = lit(SEG_C | SEG_D | SEG_E);
            5'd21: p = lit(SEG_B | SEG_C | SEG_D | SEG_E | SEG_F);
            5'd24: p = lit(SEG_B | SEG_C | SEG_D | SEG_F | SEG_G);
            5'd25: p = lit(SEG_A | SEG_B | SEG_D | SEG_E | SEG_G);
            default: p = BLANK_BYTE;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] char_pattern(input logic [7:0] c);
        logic [7:0] p;
        case (c) inside
            CHAR_SPACE:                  p = BLANK_BYTE;
            CHAR_MINUS:                  p = MINUS_BYTE;
            CHAR_UNDERSCORE:             p = lit(SEG_D);
            CHAR_COMMA, CHAR_DOT:        p = lit(SEG_P);
            [CHAR_ZERO:CHAR_NINE]:       p = num_pattern(4'(c - CHAR_ZERO));
            [CHAR_UPPER_A:CHAR_UPPER_Z]: p = letter_pattern(5'(c - CHAR_UPPER_A));
            [CHAR_LOWER_A:CHAR_LOWER_Z]: p = letter_pattern(5'(c - CHAR_LOWER_A));
            default:                     p = letter_pattern(5'd0);
        endcase
        return p;
    endfunction

endpackage

// File: rtl/ssd_num_encode.sv
// ----------------------------------------------------------------------------
// ssd_num_encode
// Turns a signed number and point position into four segment patterns.
// ----------------------------------------------------------------------------
module ssd_num_encode (
    input  logic signed [15:0] value,
    input  logic [2:0]         point_position,
    output ssd_pkg::patterns_t patterns
);
    import ssd_pkg::*;

    localparam logic [13:0] RECIP_1000 = 14'd8389;
    localparam logic [13:0] RECIP_100  = 14'd5243;
    localparam logic [13:0] RECIP_10   = 14'd6554;

    logic        out_of_range;
    logic        negative;
    logic [15:0] abs_value;
    logic [13:0] mag;
    logic [27:0] prod_1000;
    logic [27:0] prod_100;
    logic [27:0] prod_10;
    logic [3:0]  q_1000;
    logic [6:0]  q_100;
    logic [9:0]  q_10;
    logic [6:0]  rem_100;
    logic [9:0]  rem_10;
    logic [13:0] rem_1;

    always_comb
    begin
        out_of_range = (value > 16'sd9999) || (value < -16'sd999);
        negative     = value[15];
        abs_value    = negative ? 16'(-value) : 16'(value);
        mag          = abs_value[13:0];

        // reciprocal multiplies, exact over 0..9999
        prod_1000 = 28'(mag) * 28'(RECIP_1000);
        prod_100  = 28'(mag) * 28'(RECIP_100);
        prod_10   = 28'(mag) * 28'(RECIP_10);
        q_1000    = prod_1000[26:23];
        q_100     = prod_100[25:19];
        q_10      = prod_10[25:16];

        rem_100 = q_100 - 7'({3'b000, q_1000} * 7'd10);
        rem_10  = q_10 - 10'({3'b000, q_100} * 10'd10);
        rem_1   = mag - 14'({4'b0000, q_10} * 14'd10);

        if (out_of_range)
        begin
            patterns[0] = BLANK_BYTE;
            patterns[1] = letter_pattern(LETTER_O);
            patterns[2] = letter_pattern(LETTER_U);
            patterns[3] = letter_pattern(LETTER_T);
        end
        else
        begin
            if (negative)
                patterns[0] = MINUS_BYTE;
            else
                patterns[0] = (q_1000 != 4'd0) ? num_pattern(q_1000) : BLANK_BYTE;
            patterns[1] = (q_100 != 7'd0) ? num_pattern(rem_100[3:0]) : BLANK_BYTE;
            patterns[2] = (q_10 != 10'd0) ? num_pattern(rem_10[3:0]) : BLANK_BYTE;
            patterns[3] = num_pattern(rem_1[3:0]);
        end

        if (!point_position[2])
            patterns[point_position[1:0]][7] = 1'b0;
    end

endmodule

// File: rtl/ssd_out_reg.sv
// ----------------------------------------------------------------------------
// ssd_out_reg
// Result register holding one scanned digit until the receiver takes it.
// ----------------------------------------------------------------------------
module ssd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  ssd_pkg::result_t res_in,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       segment_byte,
    output logic [3:0]       digit_enable,
    output logic [1:0]       digit_index
);
    import ssd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
    end

    assign out_valid    = valid_reg;
    assign segment_byte = res_reg.segment_byte;
    assign digit_enable = res_reg.digit_enable;
    assign digit_index  = res_reg.digit_index;

endmodule

// File: rtl/four_digit_seven_segment_driver_unit.sv
// ----------------------------------------------------------------------------
// four_digit_seven_segment_driver_unit
// Four-digit multiplexed seven-segment driver with number, character,
// clear and refresh-tick transactions.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries kind, value, point_position,
//   digit_position and char_code; kinds number, char and clear update the
//   four stored active-low digit patterns and give no result
//   a tick transaction returns one result on the output channel
//   (out_valid/out_ready): segment_byte, digit_enable and digit_index of the
//   digit under the scan counter, which then wraps up by one
//   a tick moves on from the input register once the result register is free
//   throughput: one transaction per cycle while no tick waits, set by the
//   single input register feeding number split and pattern store in one pass
//   reset: all digits blank, scan counter at digit 0, no result pending
//   stall: the result register holds while out_ready is low; number, char
//   and clear transactions keep flowing, a tick waits in the input register
//   and in_ready drops only when that register cannot drain
// ----------------------------------------------------------------------------
module four_digit_seven_segment_driver_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic signed [15:0] value,
    input  logic [2:0]         point_position,
    input  logic [2:0]         digit_position,
    input  logic [7:0]         char_code,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         segment_byte,
    output logic [3:0]         digit_enable,
    output logic [1:0]         digit_index
);
    import ssd_pkg::*;

    logic      s1_valid_reg;
    logic      s1_valid_next;
    item_t     s1_item_reg;
    patterns_t patterns_reg;
    patterns_t patterns_next;
    logic [1:0] scan_reg;
    logic [1:0] scan_next;
    patterns_t num_patterns;
    result_t   res;
    logic      out_free;
    logic      load;
    logic      s1_advance;
    logic      in_accept;

    ssd_num_encode u_num_encode (
        .value          (s1_item_reg.value),
        .point_position (s1_item_reg.point_position),
        .patterns       (num_patterns)
    );

    assign s1_advance = s1_valid_reg && ((s1_item_reg.kind != KIND_TICK) || out_free);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = in_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
        patterns_next = patterns_reg;
        scan_next     = scan_reg;
        load          = 1'b0;
        if (s1_advance)
        begin
            case (s1_item_reg.kind)
                KIND_NUMBER:
                    patterns_next = num_patterns;
                KIND_CHAR:
                begin
                    if (!s1_item_reg.digit_position[2])
                        patterns_next[s1_item_reg.digit_position[1:0]] =
                            char_pattern(s1_item_reg.char_code);
                end
                KIND_CLEAR:
                    patterns_next = {4{BLANK_BYTE}};
                KIND_TICK:
                begin
                    load      = 1'b1;
                    scan_next = scan_reg + 2'd1;
                end
                default:
                    patterns_next = patterns_reg;
            endcase
        end
        res.segment_byte = patterns_reg[scan_reg];
        res.digit_enable = 4'b0001 << scan_reg;
        res.digit_index  = scan_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            patterns_reg <= {4{BLANK_BYTE}};
            scan_reg     <= 2'd0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            patterns_reg <= patterns_next;
            scan_reg     <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg.kind           <= kind_t'(kind);
            s1_item_reg.value          <= value;
            s1_item_reg.point_position <= point_position;
            s1_item_reg.digit_position <= digit_position;
            s1_item_reg.char_code      <= char_code;
        end
    end

    ssd_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .res_in       (res),
        .free         (out_free),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .segment_byte (segment_byte),
        .digit_enable (digit_enable),
        .digit_index  (digit_index)
    );

endmodule

// File: rtl/ssd_checker.sv
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks on the display driver, bound to the top level.
// ----------------------------------------------------------------------------
module ssd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [1:0]         kind,
    input logic signed [15:0] value,
    input logic [2:0]         point_position,
    input logic [2:0]         digit_position,
    input logic [7:0]         char_code,
    input logic               out_valid,
    input logic               out_ready,
    input logic [7:0]         segment_byte,
    input logic [3:0]         digit_enable,
    input logic [1:0]         digit_index
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(segment_byte)
            && $stable(digit_enable) && $stable(digit_index))
    else $error("stalled result changed");

    // select matches index
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> digit_enable == (4'b0001 << digit_index))
    else $error("digit enable does not match digit index");

    // reset leaves no pending result
    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
    else $error("result valid after reset");

    // a free result register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |=> in_ready || out_valid)
    else $error("input stalled with empty result register");

endmodule

bind four_digit_seven_segment_driver_unit ssd_checker u_ssd_checker (.*);
